FILE: rtl/bswi_pkg.sv
// Package with shared types, constants and a saturation helper function for the window integrator.
`timescale 1ns / 1ps
`default_nettype none
package bswi_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int NUM_WINDOWS = 4;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int WIN_W       = 2;

  localparam logic [1:0] CMD_SIGNAL   = 2'd0;
  localparam logic [1:0] CMD_BASELINE = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_WEN    = 3'd2;
  localparam logic [2:0] REG_AEN    = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;

  localparam logic KIND_SUM = 1'b0;
  localparam logic KIND_AVG = 1'b1;

  localparam logic signed [47:0] V48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] V48_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic               kind;
    logic [WIN_W-1:0]   window;
    logic signed [47:0] value;
    logic               last_result;
  } result_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    begin
      if (v > 64'(V48_MAX)) r = V48_MAX;
      else if (v < 64'(V48_MIN)) r = V48_MIN;
      else r = v[47:0];
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bswi_if.sv
// Valid/ready channel interfaces for input items, result items and configuration writes.
`timescale 1ns / 1ps
`default_nettype none
interface bswi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] sample;
  logic               last;
  modport source (output valid, cmd, sample, last, input ready);
  modport sink   (input valid, cmd, sample, last, output ready);
endinterface

interface bswi_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         window;
  logic signed [47:0] value;
  logic               last_result;
  modport source (output valid, kind, window, value, last_result, input ready);
  modport sink   (input valid, kind, window, value, last_result, output ready);
endinterface

interface bswi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/bswi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bswi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/bswi_div.sv
// Sequential restoring divider for the running average (64-bit by 32-bit, toward zero).
`timescale 1ns / 1ps
`default_nettype none
module bswi_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [31:0]        divisor,
  output logic                    done,
  output logic signed [63:0]      quotient
);
  logic [63:0] rem, quo_r;
  logic [64:0] acc_r;
  logic [31:0] dvs_r;
  logic        neg_r, busy_r, done_r;
  logic [5:0]  step_r;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    shifted = {acc_r[63:0], quo_r[63]};
    diff    = shifted - {33'd0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 6'd0;
        neg_r  <= dividend[63];
        quo_r  <= dividend[63] ? (64'd0 - dividend) : dividend;
        acc_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        if (!diff[64]) begin
          acc_r <= diff;
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          acc_r <= shifted;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
        if (step_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign rem      = acc_r[63:0];
  assign quotient = neg_r ? (64'd0 - quo_r) : quo_r;

  assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rem < {32'd0, dvs_r})
    else $error("divider remainder out of range");
endmodule
`default_nettype wire

FILE: rtl/baseline_subtracted_window_integrator.sv
// Top level of the baseline-subtracted gated boxcar integrator.
// Sample items stream one per cycle while the block is idle. A frame-closing
// item then walks the stored samples, a read state and an accumulate state per sample per
// enabled window (one read port per memory); no input is taken until the walk is done.
// A tick scans every window and runs the 64-step divider for each window that fires.
// Reset (synchronous, rst_n low) clears the state, configuration and accumulator registers, not the memories.
`timescale 1ns / 1ps
`default_nettype none
module baseline_subtracted_window_integrator (
  input wire logic clk,
  input wire logic rst_n,
  bswi_in_if.sink    in_ch,
  bswi_out_if.source out_ch,
  bswi_cfg_if.sink   cfg_ch
);
  localparam int AW = bswi_pkg::ADDR_W;
  localparam int CW = bswi_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_WSETUP, S_WIDX, S_RD, S_ACC, S_WDONE, S_EMIT,
    S_TWIN, S_DIV, S_DIVWAIT, S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [63:0] start_r, width_r, period_r;
  logic [3:0]  wen_r, aen_r;

  logic [CW-1:0] sig_fill_r, base_fill_r, base_len_r, n_r;
  logic signed [63:0] avg_sum_r [bswi_pkg::NUM_WINDOWS];
  logic [31:0] avg_cnt_r [bswi_pkg::NUM_WINDOWS];
  logic [31:0] ticks_r [bswi_pkg::NUM_WINDOWS];

  logic [1:0]  win_r;
  logic [CW-1:0] idx_r, end_r;
  logic signed [47:0] sum_r;   // 48 bits hold up to 4096 33-bit differences exactly
  logic [33:0] prod0_r, prod1_r;
  logic        pend_r;   // one result held back so the last one can be flagged
  bswi_pkg::result_t pend_data_r, out_r;
  logic        out_v_r;
  logic        from_div_r; // set while a tick pass emits averages

  logic signed [31:0] sig_rd, base_rd;
  logic sig_we, base_we;
  logic [AW-1:0] rd_addr;

  logic div_start, div_done;
  logic signed [63:0] div_q;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE) && !pend_r;
  wire in_acc = in_ch.valid && in_ch.ready;

  assign sig_we  = in_acc && in_ch.cmd == bswi_pkg::CMD_SIGNAL &&
                   sig_fill_r < CW'(bswi_pkg::MAX_SAMPLES);
  assign base_we = in_acc && in_ch.cmd == bswi_pkg::CMD_BASELINE &&
                   base_fill_r < CW'(bswi_pkg::MAX_SAMPLES);
  assign rd_addr = idx_r[AW-1:0];

  bswi_ram #(.WIDTH(32), .DEPTH(bswi_pkg::MAX_SAMPLES)) u_sig (
    .clk, .we(sig_we), .waddr(sig_fill_r[AW-1:0]), .wdata(in_ch.sample),
    .raddr(rd_addr), .rdata(sig_rd));
  bswi_ram #(.WIDTH(32), .DEPTH(bswi_pkg::MAX_SAMPLES)) u_base (
    .clk, .we(base_we), .waddr(base_fill_r[AW-1:0]), .wdata(in_ch.sample),
    .raddr(rd_addr), .rdata(base_rd));

  bswi_div u_div (.clk, .rst_n, .start(div_start), .dividend(avg_sum_r[win_r]),
    .divisor(avg_cnt_r[win_r]), .done(div_done), .quotient(div_q));
  assign div_start = (state_r == S_DIV);

  // Window fields for the current window.
  logic [15:0] st_f, wd_f, per_f;
  always_comb begin
    st_f  = start_r[16*win_r +: 16];
    wd_f  = width_r[16*win_r +: 16];
    per_f = period_r[16*win_r +: 16];
  end

  // Index products: 16-bit start and 17-bit end fraction by 13-bit length, one multiply each, registered.
  logic [CW-1:0] i0_c, i1_c;
  always_comb begin
    i0_c = (prod0_r[33:14] >= 20'(n_r)) ? n_r - CW'(1) : CW'(prod0_r[33:14]);
    i1_c = (prod1_r[33:14] > 20'(n_r)) ? n_r : CW'(prod1_r[33:14]);
  end

  // Sample difference, with a zero baseline past the stored baseline length.
  logic [CW-1:0] rd_idx_r;
  logic signed [32:0] diff_c;
  always_comb begin
    diff_c = 33'(sig_rd) - ((rd_idx_r < base_len_r) ? 33'(base_rd) : 33'sd0);
  end

  logic signed [63:0] add_c;
  always_comb begin
    add_c = avg_sum_r[win_r] + 64'(sum_r);
    if (!avg_sum_r[win_r][63] && !sum_r[47] && add_c[63]) add_c = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (avg_sum_r[win_r][63] && sum_r[47] && !add_c[63]) add_c = 64'h8000_0000_0000_0000;
  end

  // A new result enters the held slot while the previously held one moves to the
  // output register; at the end of the item the held one leaves flagged as last.
  logic push, flush;
  bswi_pkg::result_t push_data, flush_data, avg_res;
  wire out_free = !out_v_r || out_ch.ready;

  always_comb begin
    avg_res.kind        = bswi_pkg::KIND_AVG;
    avg_res.window      = win_r;
    avg_res.value       = bswi_pkg::sat48(div_q);
    avg_res.last_result = 1'b0;
    push_data.kind        = bswi_pkg::KIND_SUM;
    push_data.window      = win_r;
    push_data.value       = sum_r;
    push_data.last_result = 1'b0;
    if (from_div_r) push_data = avg_res;
    flush_data             = pend_data_r;
    flush_data.last_result = 1'b1;
    push  = (state_r == S_EMIT) && (!pend_r || out_free);
    flush = (state_r == S_DONE) && pend_r && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      width_r     <= 64'h4000_4000_4000_4000;
      period_r    <= 64'h012C_012C_012C_012C;
      wen_r       <= 4'd1;
      aen_r       <= 4'd0;
      sig_fill_r  <= '0;
      base_fill_r <= '0;
      base_len_r  <= '0;
      out_v_r     <= 1'b0;
      pend_r      <= 1'b0;
      from_div_r  <= 1'b0;
      for (int w = 0; w < bswi_pkg::NUM_WINDOWS; w++) begin
        avg_sum_r[w] <= '0;
        avg_cnt_r[w] <= '0;
        ticks_r[w]   <= '0;
      end
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          bswi_pkg::REG_START:  start_r  <= cfg_ch.data;
          bswi_pkg::REG_WIDTH:  width_r  <= cfg_ch.data;
          bswi_pkg::REG_WEN:    wen_r    <= cfg_ch.data[3:0];
          bswi_pkg::REG_AEN:    aen_r    <= cfg_ch.data[3:0];
          bswi_pkg::REG_PERIOD: period_r <= cfg_ch.data;
          default: ;
        endcase
      end

      // Output register and held slot.
      if (flush) begin
        out_r   <= flush_data;
        out_v_r <= 1'b1;
        pend_r  <= 1'b0;
      end else if (push && pend_r) begin
        out_r   <= pend_data_r;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (push) begin
        pend_data_r <= push_data;
        pend_r      <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          win_r      <= '0;
          from_div_r <= 1'b0;
          if (in_acc) begin
            unique case (in_ch.cmd)
              bswi_pkg::CMD_SIGNAL: begin
                if (sig_we) sig_fill_r <= sig_fill_r + CW'(1);
                if (in_ch.last) begin
                  n_r        <= sig_we ? sig_fill_r + CW'(1) : sig_fill_r;
                  sig_fill_r <= '0;
                  state_r    <= (sig_we || sig_fill_r != '0) ? S_WSETUP : S_DONE;
                end
              end
              bswi_pkg::CMD_BASELINE: begin
                if (in_ch.last) begin
                  base_len_r  <= base_we ? base_fill_r + CW'(1) : base_fill_r;
                  base_fill_r <= '0;
                end else if (base_we) base_fill_r <= base_fill_r + CW'(1);
              end
              bswi_pkg::CMD_TICK: begin
                for (int w = 0; w < bswi_pkg::NUM_WINDOWS; w++)
                  if (ticks_r[w] != 32'hFFFF_FFFF) ticks_r[w] <= ticks_r[w] + 32'd1;
                state_r <= S_TWIN;
              end
              default: ;
            endcase
          end
        end
        S_WSETUP: begin
          if (!wen_r[win_r]) begin
            if (win_r == 2'(bswi_pkg::NUM_WINDOWS - 1)) state_r <= S_DONE;
            else win_r <= win_r + 2'd1;
          end else begin
            prod0_r <= 34'(st_f) * 34'(n_r);
            prod1_r <= (34'(st_f) + 34'(wd_f)) * 34'(n_r);
            state_r <= S_WIDX;
          end
        end
        S_WIDX: begin
          idx_r   <= i0_c;
          end_r   <= i1_c;
          sum_r   <= '0;
          state_r <= (i0_c < i1_c) ? S_RD : S_WDONE;
        end
        S_RD: begin
          rd_idx_r <= idx_r;
          idx_r    <= idx_r + CW'(1);
          state_r  <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_r + 48'(diff_c);
          state_r <= (idx_r < end_r) ? S_RD : S_WDONE;
        end
        S_WDONE: begin
          if (aen_r[win_r]) begin
            avg_sum_r[win_r] <= add_c;
            if (avg_cnt_r[win_r] != 32'hFFFF_FFFF) avg_cnt_r[win_r] <= avg_cnt_r[win_r] + 32'd1;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          // Sums return to the frame walk, averages to the tick scan.
          if (push) begin
            if (from_div_r) begin
              avg_sum_r[win_r] <= '0;
              avg_cnt_r[win_r] <= '0;
            end
            if (win_r == 2'(bswi_pkg::NUM_WINDOWS - 1)) state_r <= S_DONE;
            else begin
              win_r   <= win_r + 2'd1;
              state_r <= from_div_r ? S_TWIN : S_WSETUP;
            end
          end
        end
        S_TWIN: begin
          if (wen_r[win_r] && aen_r[win_r] && ticks_r[win_r] >= 32'(per_f)) begin
            ticks_r[win_r] <= '0;
            if (avg_cnt_r[win_r] != '0) state_r <= S_DIV;
            else begin
              avg_sum_r[win_r] <= '0;
              if (win_r == 2'(bswi_pkg::NUM_WINDOWS - 1)) state_r <= S_DONE;
              else win_r <= win_r + 2'd1;
            end
          end else if (win_r == 2'(bswi_pkg::NUM_WINDOWS - 1)) state_r <= S_DONE;
          else win_r <= win_r + 2'd1;
        end
        S_DIV: begin
          from_div_r <= 1'b1;
          state_r    <= S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) state_r <= S_EMIT;
        end
        S_DONE: begin
          if (!pend_r) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.window      = out_r.window;
  assign out_ch.value       = out_r.value;
  assign out_ch.last_result = out_r.last_result;

  assert property (@(posedge clk) disable iff (!rst_n) in_acc |-> state_r == S_IDLE)
    else $error("item accepted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> rd_idx_r < end_r)
    else $error("read beyond window end");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("result held while idle");
endmodule
`default_nettype wire

FILE: verif/tb_baseline_subtracted_window_integrator.sv
// Self-checking testbench for the baseline-subtracted gated boxcar integrator.
`timescale 1ns / 1ps
`default_nettype none
module tb_baseline_subtracted_window_integrator;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int NW = bswi_pkg::NUM_WINDOWS;
  localparam int MS = bswi_pkg::MAX_SAMPLES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #4 clk = ~clk;

  bswi_in_if  in_ch();
  bswi_out_if out_ch();
  bswi_cfg_if cfg_ch();

  baseline_subtracted_window_integrator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Local copy of the block's state and configuration.
  logic [63:0] cur_starts, cur_widths, cur_periods;
  logic [3:0]  cur_wen, cur_aen;
  logic [31:0] sig_mem [0:MS-1];
  logic [31:0] base_mem [0:MS-1];
  int unsigned base_len, base_fill, sig_fill;
  longint      avg_acc [NW];
  int unsigned avg_cnt [NW];
  int unsigned ticks [NW];

  bswi_pkg::result_t pending_results [$];
  int          last_produced = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          long_stall = 1'b0;
  bit          no_idle = 1'b0;
  localparam int CYCLE_LIMIT = 4000000;

  function automatic longint clip48(input longint v);
    longint hi, lo;
    hi = 64'sh7FFF_FFFF_FFFF;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint acc_add(input longint a, input longint b);
    longint s;
    s = a + b;
    // Signed overflow shows as a sign flip with equal-sign operands.
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? 64'sh8000_0000_0000_0000
                                                     : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic void queue_result(input logic kind, input int w, input longint v);
    bswi_pkg::result_t r;
    r.kind = kind;
    r.window = w[1:0];
    r.value = v[47:0];
    r.last_result = 1'b0;
    pending_results = {pending_results, r};
  endfunction

  // Mark the final result of the item whose expectations start at index first.
  function automatic void mark_last(input int first);
    if (pending_results.size() > first)
      pending_results[pending_results.size()-1].last_result = 1'b1;
  endfunction

  // Frame closing: one baseline-subtracted sum per enabled window.
  function automatic void integrate_frame();
    longint unsigned n, st, wd, i0, i1;
    longint sum, b;
    n = sig_fill;
    sig_fill = 0;
    if (n == 0) return;
    for (int w = 0; w < NW; w++) begin
      if (!cur_wen[w]) continue;
      st = cur_starts[16*w +: 16];
      wd = cur_widths[16*w +: 16];
      i0 = (st * n) >> 14;
      i1 = ((st + wd) * n) >> 14;
      if (i0 >= n) i0 = n - 1;
      if (i1 > n) i1 = n;
      sum = 0;
      for (longint unsigned i = i0; i < i1; i++) begin
        b = (i < base_len) ? longint'($signed(base_mem[i])) : 0;
        sum += longint'($signed(sig_mem[i])) - b;
      end
      sum = clip48(sum);
      queue_result(bswi_pkg::KIND_SUM, w, sum);
      if (cur_aen[w]) begin
        avg_acc[w] = acc_add(avg_acc[w], sum);
        if (avg_cnt[w] != 32'hFFFF_FFFF) avg_cnt[w]++;
      end
    end
  endfunction

  // Tick: advance every timer and emit averages for due windows that have summed frames.
  function automatic void advance_timers();
    for (int w = 0; w < NW; w++) begin
      if (ticks[w] != 32'hFFFF_FFFF) ticks[w]++;
      if (!cur_wen[w] || !cur_aen[w]) continue;
      if (ticks[w] < cur_periods[16*w +: 16]) continue;
      if (avg_cnt[w] != 0)
        queue_result(bswi_pkg::KIND_AVG, w, clip48(avg_acc[w] / longint'(avg_cnt[w])));
      avg_acc[w] = 0;
      avg_cnt[w] = 0;
      ticks[w] = 0;
    end
  endfunction

  function automatic void predict_item(input logic [1:0] cmd, input logic [31:0] s,
                                       input logic lst);
    int first;
    first = pending_results.size();
    if (cmd == bswi_pkg::CMD_SIGNAL) begin
      if (sig_fill < MS) sig_mem[sig_fill++] = s;
      if (lst) integrate_frame();
    end else if (cmd == bswi_pkg::CMD_BASELINE) begin
      if (base_fill < MS) base_mem[base_fill++] = s;
      if (lst) begin
        base_len = base_fill;
        base_fill = 0;
      end
    end else if (cmd == bswi_pkg::CMD_TICK) begin
      advance_timers();
    end
    mark_last(first);
    last_produced = pending_results.size() - first;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] d);
    case (idx)
      bswi_pkg::REG_START:  cur_starts = d;
      bswi_pkg::REG_WIDTH:  cur_widths = d;
      bswi_pkg::REG_WEN:    cur_wen = d[3:0];
      bswi_pkg::REG_AEN:    cur_aen = d[3:0];
      bswi_pkg::REG_PERIOD: cur_periods = d;
      default: ;
    endcase
  endfunction

  function automatic bit want_idle();
    if (no_idle) return 1'b0;
    return $urandom_range(99) < 25;
  endfunction

  // Driving of all block inputs happens at the falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_reg(idx, d);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one item, with an optional random gap first; the prediction is made
  // at the edge where the block takes it.
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] s, input logic lst);
    while (want_idle()) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= cmd;
    in_ch.sample <= s;
    in_ch.last   <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(cmd, s, lst);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until all predicted results have come back, then lets the block
  // finish any work that yields no result.
  task automatic drain();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Receiver: ready is driven at the falling edge, with random hold-offs and one
  // long stall that the stimulus process requests.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (long_stall) out_ch.ready <= 1'b0;
    else out_ch.ready <= !want_idle();
  end

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    bswi_pkg::result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: kind %0d window %0d value %0d last %0d",
                   out_ch.kind, out_ch.window, out_ch.value, out_ch.last_result);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.kind !== exp_r.kind || out_ch.window !== exp_r.window ||
            out_ch.value !== exp_r.value || out_ch.last_result !== exp_r.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected kind %0d window %0d value %0d last %0d,",
                      " got %0d %0d %0d %0d"},
                     exp_r.kind, exp_r.window, exp_r.value, exp_r.last_result,
                     out_ch.kind, out_ch.window, out_ch.value, out_ch.last_result);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed rows: a few carry a hand-read expected result, the rest rely on the predictor.
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] sample;
    logic        last;
    bit          has_exp;
    logic        exp_kind;
    logic signed [47:0] exp_value;
  } row_t;

  row_t directed_rows [] = '{
    // Single-sample frame right after reset: default window spans it all, no baseline.
    '{bswi_pkg::CMD_SIGNAL, 32'sd5, 1'b1, 1'b1, bswi_pkg::KIND_SUM, 48'sd5},
    '{bswi_pkg::CMD_SIGNAL, 32'h7FFF_FFFF, 1'b1, 1'b1, bswi_pkg::KIND_SUM, 48'sh7FFF_FFFF},
    '{bswi_pkg::CMD_SIGNAL, 32'h8000_0000, 1'b1, 1'b1, bswi_pkg::KIND_SUM, -48'sh8000_0000},
    // Baseline load of three samples, then a frame subtracting it.
    '{bswi_pkg::CMD_BASELINE, 32'h7FFF_FFFF, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_BASELINE, 32'h8000_0000, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_BASELINE, 32'sd1, 1'b1, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_SIGNAL, 32'h8000_0000, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_SIGNAL, 32'h7FFF_FFFF, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_SIGNAL, 32'hFFFF_FFFF, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    // Longer than the baseline: the tail is taken with zero baseline.
    '{bswi_pkg::CMD_SIGNAL, 32'h1234_5678, 1'b1, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    // Ticks with averaging off give nothing; an unknown command is ignored.
    '{bswi_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b1, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    // Baseline reload left open, so the next frame sees mixed entries.
    '{bswi_pkg::CMD_BASELINE, 32'sd100, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_SIGNAL, 32'sd7, 1'b0, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_SIGNAL, 32'sd9, 1'b1, 1'b0, bswi_pkg::KIND_SUM, 48'sd0},
    '{bswi_pkg::CMD_BASELINE, 32'sd3, 1'b1, 1'b0, bswi_pkg::KIND_SUM, 48'sd0}
  };

  task automatic run_directed();
    for (int i = 0; i < directed_rows.size(); i++) begin
      send_item(directed_rows[i].cmd, directed_rows[i].sample, directed_rows[i].last);
      if (directed_rows[i].has_exp) begin
        if (last_produced != 1 ||
            pending_results[pending_results.size()-1].kind !== directed_rows[i].exp_kind ||
            pending_results[pending_results.size()-1].value !== directed_rows[i].exp_value)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("Directed row %0d: predictor disagrees with expected value %0d",
                     i, directed_rows[i].exp_value);
        end
      end
    end
    drain();
  endtask

  // Frames of random short lengths, with samples sometimes at the 32-bit extremes.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++)
      send_item(bswi_pkg::CMD_SIGNAL, rand_sample(), k == len - 1);
  endtask

  task automatic send_baseline(input int len);
    for (int k = 0; k < len; k++)
      send_item(bswi_pkg::CMD_BASELINE, rand_sample(), k == len - 1);
  endtask

  // A random-content phase mixing frames, baselines, ticks and noise.
  task automatic random_phase(input int items);
    int sent;
    int pick;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(9);
      if (pick < 5) begin
        pick = $urandom_range(1, 12);
        send_frame(pick);
        sent += pick;
      end else if (pick < 7) begin
        pick = $urandom_range(1, 12);
        send_baseline(pick);
        sent += pick;
      end else if (pick < 9) begin
        send_item(bswi_pkg::CMD_TICK, $urandom, 1'($urandom_range(1)));
        sent++;
      end else begin
        send_item(CMD_UNKNOWN, $urandom, 1'($urandom_range(1)));
        sent++;
      end
    end
    drain();
  endtask

  function automatic logic [63:0] rand_fracs(input int top);
    logic [63:0] v;
    for (int w = 0; w < NW; w++) v[16*w +: 16] = 16'($urandom_range(top));
    return v;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = bswi_pkg::CMD_SIGNAL;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = bswi_pkg::REG_START;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    apply_reg(bswi_pkg::REG_START, 64'h0);
    apply_reg(bswi_pkg::REG_WIDTH, 64'h4000_4000_4000_4000);
    apply_reg(bswi_pkg::REG_WEN, 64'h1);
    apply_reg(bswi_pkg::REG_AEN, 64'h0);
    apply_reg(bswi_pkg::REG_PERIOD, 64'h012C_012C_012C_012C);
    base_len = 0;
    base_fill = 0;
    sig_fill = 0;
    for (int w = 0; w < NW; w++) begin
      avg_acc[w] = 0;
      avg_cnt[w] = 0;
      ticks[w] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();

    // All windows on with averaging and short periods; starts past the end
    // and widths to the top of the Q2.14 range exercise the clamps.
    write_reg(bswi_pkg::REG_WEN, 64'hF);
    write_reg(bswi_pkg::REG_AEN, 64'hF);
    write_reg(bswi_pkg::REG_PERIOD, 64'h0003_0002_0001_0000);
    write_reg(bswi_pkg::REG_START, 64'hFFFF_8000_2000_0000);
    write_reg(bswi_pkg::REG_WIDTH, 64'hFFFF_0000_4000_2000);
    random_phase(100);

    // Random fractions, mixed enables, with a long run where no side idles.
    write_reg(bswi_pkg::REG_START, rand_fracs(16384));
    write_reg(bswi_pkg::REG_WIDTH, rand_fracs(32768));
    write_reg(bswi_pkg::REG_WEN, 64'($urandom_range(1, 15)));
    write_reg(bswi_pkg::REG_AEN, 64'($urandom_range(15)));
    write_reg(bswi_pkg::REG_PERIOD, rand_fracs(4));
    no_idle = 1'b1;
    random_phase(80);
    no_idle = 1'b0;

    // Receiver holds off while frames keep coming, so the block backs up.
    write_reg(bswi_pkg::REG_START, 64'h0);
    write_reg(bswi_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(bswi_pkg::REG_PERIOD, 64'hFFFF_FFFF_FFFF_FFFF);
    fork
      begin
        long_stall = 1'b1;
        repeat (600) @(posedge clk);
        long_stall = 1'b0;
      end
      begin
        for (int f = 0; f < 8; f++) send_frame(3);
      end
    join
    drain();

    write_reg(bswi_pkg::REG_WEN, 64'hF);
    write_reg(bswi_pkg::REG_AEN, 64'hF);
    write_reg(bswi_pkg::REG_PERIOD, rand_fracs(6));
    write_reg(bswi_pkg::REG_START, rand_fracs(20000));
    write_reg(bswi_pkg::REG_WIDTH, rand_fracs(65535));
    random_phase(150);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
